// ===== hw/rtl/vtsa_pkg.sv =====
// Shared types, widths and constants for the vector to spherical angle pipeline.
// Holds the arctangent table and per-lane helper functions; no dependencies.
`default_nettype none

package vtsa_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // input and internal widths
  localparam int XW       = 24;            // vector component
  localparam int PROD_W   = 2 * XW - 1;    // one square, always non-negative
  localparam int ROOT_W   = 32;            // horizontal length, 8 fraction bits
  localparam int RAD_W    = 2 * ROOT_W;    // sqrt radicand
  localparam int REM_W    = ROOT_W + 3;    // sqrt partial remainder
  localparam int RAD_FRAC = RAD_W - PROD_W - 1;
  localparam int AW       = 36;            // CORDIC x/y datapath
  localparam int MAW      = 33;            // magnitude used for normalization
  localparam int ACC_W    = 35;            // angle accumulator, 2^-30 rad units
  localparam int POL_PRE  = 8;             // z is scaled by 256 to match root

  // normalization: shift pairs left until max magnitude reaches 2^NORM_TOP
  localparam int NORM_TOP    = 30;
  localparam int NORM_STAGES = 5;

  // output rounding from 2^-30 to 2^-13 rad
  localparam int RND_SH   = 17;
  localparam int RND_W    = ACC_W + 1 - RND_SH;
  localparam int RND_HALF = 65536;

  localparam int OUT_POL_W = 15;
  localparam int OUT_AZ_W  = 16;

  localparam logic signed [ACC_W-1:0] ANG_PI = 35'sd3373259426;
  localparam logic signed [RND_W-1:0] OUT_PI = 19'sd25736;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic signed [AW-1:0]    a;
    logic signed [AW-1:0]    b;
    logic signed [ACC_W-1:0] acc;
    logic [MAW-1:0]          ma;
    logic                    bzero;    // second operand zero: fixed result
    logic                    spec_pi;  // first operand negative
  } lane_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [ACC_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      5'd0:    v = 35'sd843314856;
      5'd1:    v = 35'sd497837829;
      5'd2:    v = 35'sd263043836;
      5'd3:    v = 35'sd133525158;
      5'd4:    v = 35'sd67021686;
      5'd5:    v = 35'sd33543515;
      5'd6:    v = 35'sd16775850;
      5'd7:    v = 35'sd8388437;
      5'd8:    v = 35'sd4194282;
      5'd9:    v = 35'sd2097149;
      5'd10:   v = 35'sd1048575;
      5'd11:   v = 35'sd524287;
      5'd12:   v = 35'sd262143;
      5'd13:   v = 35'sd131071;
      5'd14:   v = 35'sd65535;
      5'd15:   v = 35'sd32767;
      5'd16:   v = 35'sd16383;
      5'd17:   v = 35'sd8191;
      5'd18:   v = 35'sd4095;
      5'd19:   v = 35'sd2047;
      5'd20:   v = 35'sd1023;
      5'd21:   v = 35'sd511;
      5'd22:   v = 35'sd255;
      5'd23:   v = 35'sd127;
      5'd24:   v = 35'sd63;
      5'd25:   v = 35'sd31;
      5'd26:   v = 35'sd15;
      5'd27:   v = 35'sd7;
      5'd28:   v = 35'sd3;
      5'd29:   v = 35'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // fold the left half plane onto the right, start acc at +/-pi
  function automatic lane_t lane_prep(input logic signed [AW-1:0] a,
                                      input logic signed [AW-1:0] b);
    lane_t                l;
    logic                 aneg;
    logic signed [AW-1:0] na;
    logic signed [AW-1:0] nb;
    logic signed [AW-1:0] abs_b;
    aneg  = a[AW-1];
    na    = aneg ? -a : a;
    nb    = aneg ? -b : b;
    abs_b = b[AW-1] ? -b : b;
    l.a       = na;
    l.b       = nb;
    l.acc     = aneg ? (b[AW-1] ? -ANG_PI : ANG_PI) : '0;
    l.ma      = (na > abs_b) ? na[MAW-1:0] : abs_b[MAW-1:0];
    l.bzero   = (b == '0);
    l.spec_pi = aneg;
    return l;
  endfunction

  // round half up to 2^-13 rad, or the fixed answer when b was zero
  function automatic logic signed [RND_W-1:0] lane_angle(input lane_t l);
    logic signed [ACC_W:0] s;
    s = {l.acc[ACC_W-1], l.acc} + (ACC_W+1)'(RND_HALF);
    if (l.bzero) begin
      return l.spec_pi ? OUT_PI : '0;
    end
    return $signed(s[ACC_W:RND_SH]);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vector_to_spherical_angles.sv =====
// Top level: pipelined cartesian to spherical angle converter.
// Depends on vtsa_pkg (widths, atan table, lane helper functions).
`default_nettype none

// Usage
//   Input channel in_*: one signed 24-bit vector (x, y, z) per transaction,
//   taken at a rising edge with in_valid high and in_stall low.
//   Output channel out_*: one transaction per input, in order: polar angle
//   atan2(sqrt(x^2+y^2), z) and azimuth atan2(y, x), radians * 8192, plus a
//   zero_length flag for the all-zero vector (both angles then read 0).
// Stages, from acceptance to out_valid: squares, sum, 32 square-root
//   digit stages (one result bit each), fold, 5 normalize-shift stages,
//   CORDIC_STEPS vectoring stages (two lanes side by side), round/clamp.
// Throughput: one transaction per cycle while not stalled; the
//   square-root digit stage and the CORDIC add/subtract stage set the clock.
// Stall: the whole pipeline advances as one; when the output register
//   holds a transaction and out_stall is high, everything freezes and
//   in_stall goes high. Nothing is dropped or repeated.
// Reset: synchronous active-low rst_n clears all stage valid bits; the
//   pipe is empty and ready the cycle after reset is released.
module vector_to_spherical_angles #(
  parameter int CORDIC_STEPS = vtsa_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [vtsa_pkg::XW-1:0]        in_vec_x,
  input  wire logic signed [vtsa_pkg::XW-1:0]        in_vec_y,
  input  wire logic signed [vtsa_pkg::XW-1:0]        in_vec_z,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [vtsa_pkg::OUT_POL_W-1:0]             out_polar_angle,
  output logic signed [vtsa_pkg::OUT_AZ_W-1:0]       out_azimuth_angle,
  output logic                                       out_zero_length
);

  localparam int SQ = vtsa_pkg::ROOT_W;                          // sqrt digit stages
  localparam int NS = vtsa_pkg::NORM_STAGES;
  localparam int NL = NS + 1 + CORDIC_STEPS;                     // lane stages

  // global advance: freeze only when the output holds a stalled transaction
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------------
  // Stage 1: squares
  // ---------------------------------------------------------------------
  logic                              mul_v_r;
  vtsa_pkg::vec_t                    mul_vec_r;
  logic [vtsa_pkg::PROD_W-1:0]       mul_xx_r;
  logic [vtsa_pkg::PROD_W-1:0]       mul_yy_r;
  logic signed [2*vtsa_pkg::XW-1:0]  px_nxt;
  logic signed [2*vtsa_pkg::XW-1:0]  py_nxt;

  assign px_nxt = in_vec_x * in_vec_x;
  assign py_nxt = in_vec_y * in_vec_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (adv) begin
      mul_v_r <= in_valid;
    end
    if (adv) begin
      mul_vec_r.x    <= in_vec_x;
      mul_vec_r.y    <= in_vec_y;
      mul_vec_r.z    <= in_vec_z;
      mul_vec_r.zero <= (in_vec_x == '0) && (in_vec_y == '0) && (in_vec_z == '0);
      mul_xx_r       <= px_nxt[vtsa_pkg::PROD_W-1:0];
      mul_yy_r       <= py_nxt[vtsa_pkg::PROD_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: radicand = (x^2 + y^2) * 2^16, then 32 sqrt digit stages
  // ---------------------------------------------------------------------
  logic                           sq_v_r    [0:SQ];
  vtsa_pkg::vec_t                 sq_vec_r  [0:SQ];
  logic [vtsa_pkg::RAD_W-1:0]     sq_rad_r  [0:SQ];
  logic [vtsa_pkg::REM_W-1:0]     sq_rem_r  [0:SQ];
  logic [vtsa_pkg::ROOT_W-1:0]    sq_root_r [0:SQ];
  logic [vtsa_pkg::PROD_W:0]      sum_nxt;

  assign sum_nxt = {1'b0, mul_xx_r} + {1'b0, mul_yy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= mul_v_r;
    end
    if (adv) begin
      sq_vec_r[0]  <= mul_vec_r;
      sq_rad_r[0]  <= {sum_nxt, {vtsa_pkg::RAD_FRAC{1'b0}}};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [vtsa_pkg::REM_W-1:0]  rem_w;
    logic [vtsa_pkg::REM_W-1:0]  trial;
    logic [vtsa_pkg::REM_W-1:0]  rem_nxt;
    logic [vtsa_pkg::ROOT_W-1:0] root_nxt;

    always_comb begin
      rem_w = {sq_rem_r[j][vtsa_pkg::REM_W-3:0], sq_rad_r[j][vtsa_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, sq_root_r[j], 2'b01};
      if (rem_w >= trial) begin
        rem_nxt  = rem_w - trial;
        root_nxt = {sq_root_r[j][vtsa_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_w;
        root_nxt = {sq_root_r[j][vtsa_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
      if (adv) begin
        sq_vec_r[j+1]  <= sq_vec_r[j];
        sq_rad_r[j+1]  <= {sq_rad_r[j][vtsa_pkg::RAD_W-3:0], 2'b00};
        sq_rem_r[j+1]  <= rem_nxt;
        sq_root_r[j+1] <= root_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Lane stages: fold, normalize, CORDIC. Polar lane atan2(r, 256 z),
  // azimuth lane atan2(y, x).
  // ---------------------------------------------------------------------
  logic                 ln_v_r    [0:NL-1];
  logic                 ln_zero_r [0:NL-1];
  vtsa_pkg::lane_t      ln_pol_r  [0:NL-1];
  vtsa_pkg::lane_t      ln_az_r   [0:NL-1];

  logic signed [vtsa_pkg::AW-1:0] pol_a;
  logic signed [vtsa_pkg::AW-1:0] pol_b;
  logic signed [vtsa_pkg::AW-1:0] az_a;
  logic signed [vtsa_pkg::AW-1:0] az_b;

  always_comb begin
    pol_a = {{(vtsa_pkg::AW-vtsa_pkg::XW-vtsa_pkg::POL_PRE){sq_vec_r[SQ].z[vtsa_pkg::XW-1]}},
             sq_vec_r[SQ].z, {vtsa_pkg::POL_PRE{1'b0}}};
    pol_b = {{(vtsa_pkg::AW-vtsa_pkg::ROOT_W){1'b0}}, sq_root_r[SQ]};
    az_a  = {{(vtsa_pkg::AW-vtsa_pkg::XW){sq_vec_r[SQ].x[vtsa_pkg::XW-1]}}, sq_vec_r[SQ].x};
    az_b  = {{(vtsa_pkg::AW-vtsa_pkg::XW){sq_vec_r[SQ].y[vtsa_pkg::XW-1]}}, sq_vec_r[SQ].y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ln_v_r[0] <= 1'b0;
    end else if (adv) begin
      ln_v_r[0] <= sq_v_r[SQ];
    end
    if (adv) begin
      ln_zero_r[0] <= sq_vec_r[SQ].zero;
      ln_pol_r[0]  <= vtsa_pkg::lane_prep(pol_a, pol_b);
      ln_az_r[0]   <= vtsa_pkg::lane_prep(az_a, az_b);
    end
  end

  // normalize: shifts of 16, 8, 4, 2, 1, each taken while max stays below 2^31
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 1 << (NS - 1 - k);
    localparam logic [vtsa_pkg::MAW-1:0] LIM =
      vtsa_pkg::MAW'(1) << (vtsa_pkg::NORM_TOP + 1 - SH);
    vtsa_pkg::lane_t pol_nxt;
    vtsa_pkg::lane_t az_nxt;

    always_comb begin
      pol_nxt = ln_pol_r[k];
      az_nxt  = ln_az_r[k];
      if (ln_pol_r[k].ma < LIM) begin
        pol_nxt.a  = ln_pol_r[k].a <<< SH;
        pol_nxt.b  = ln_pol_r[k].b <<< SH;
        pol_nxt.ma = ln_pol_r[k].ma << SH;
      end
      if (ln_az_r[k].ma < LIM) begin
        az_nxt.a  = ln_az_r[k].a <<< SH;
        az_nxt.b  = ln_az_r[k].b <<< SH;
        az_nxt.ma = ln_az_r[k].ma << SH;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ln_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        ln_v_r[k+1] <= ln_v_r[k];
      end
      if (adv) begin
        ln_zero_r[k+1] <= ln_zero_r[k];
        ln_pol_r[k+1]  <= pol_nxt;
        ln_az_r[k+1]   <= az_nxt;
      end
    end
  end

  // CORDIC vectoring, one iteration per stage, both lanes in parallel
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam int          SRC = NS + i;
    localparam logic [4:0]  IDX = 5'(i);
    logic signed [vtsa_pkg::AW-1:0]    pa;
    logic signed [vtsa_pkg::AW-1:0]    pb;
    logic signed [vtsa_pkg::AW-1:0]    za;
    logic signed [vtsa_pkg::AW-1:0]    zb;
    logic signed [vtsa_pkg::ACC_W-1:0] ang;
    vtsa_pkg::lane_t                   pol_nxt;
    vtsa_pkg::lane_t                   az_nxt;

    always_comb begin
      pa  = ln_pol_r[SRC].a;
      pb  = ln_pol_r[SRC].b;
      za  = ln_az_r[SRC].a;
      zb  = ln_az_r[SRC].b;
      ang = vtsa_pkg::atan_lut(IDX);
      pol_nxt = ln_pol_r[SRC];
      az_nxt  = ln_az_r[SRC];
      if (pb > 0) begin
        pol_nxt.a   = pa + (pb >>> IDX);
        pol_nxt.b   = pb - (pa >>> IDX);
        pol_nxt.acc = ln_pol_r[SRC].acc + ang;
      end else begin
        pol_nxt.a   = pa - (pb >>> IDX);
        pol_nxt.b   = pb + (pa >>> IDX);
        pol_nxt.acc = ln_pol_r[SRC].acc - ang;
      end
      if (zb > 0) begin
        az_nxt.a   = za + (zb >>> IDX);
        az_nxt.b   = zb - (za >>> IDX);
        az_nxt.acc = ln_az_r[SRC].acc + ang;
      end else begin
        az_nxt.a   = za - (zb >>> IDX);
        az_nxt.b   = zb + (za >>> IDX);
        az_nxt.acc = ln_az_r[SRC].acc - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ln_v_r[SRC+1] <= 1'b0;
      end else if (adv) begin
        ln_v_r[SRC+1] <= ln_v_r[SRC];
      end
      if (adv) begin
        ln_zero_r[SRC+1] <= ln_zero_r[SRC];
        ln_pol_r[SRC+1]  <= pol_nxt;
        ln_az_r[SRC+1]   <= az_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: round, clamp
  // ---------------------------------------------------------------------
  logic signed [vtsa_pkg::RND_W-1:0]    pol_rnd;
  logic signed [vtsa_pkg::RND_W-1:0]    az_rnd;
  logic signed [vtsa_pkg::RND_W-1:0]    pol_nxt;
  logic signed [vtsa_pkg::RND_W-1:0]    az_nxt;
  logic [vtsa_pkg::OUT_POL_W-1:0]       out_polar_angle_r;
  logic signed [vtsa_pkg::OUT_AZ_W-1:0] out_azimuth_angle_r;
  logic                                 out_zero_length_r;

  always_comb begin
    pol_rnd = vtsa_pkg::lane_angle(ln_pol_r[NL-1]);
    az_rnd  = vtsa_pkg::lane_angle(ln_az_r[NL-1]);
    pol_nxt = pol_rnd;
    if (pol_rnd < 0) begin
      pol_nxt = '0;
    end else if (pol_rnd > vtsa_pkg::OUT_PI) begin
      pol_nxt = vtsa_pkg::OUT_PI;
    end
    az_nxt = az_rnd;
    if (az_rnd < -vtsa_pkg::OUT_PI) begin
      az_nxt = -vtsa_pkg::OUT_PI;
    end else if (az_rnd > vtsa_pkg::OUT_PI) begin
      az_nxt = vtsa_pkg::OUT_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ln_v_r[NL-1];
    end
    if (adv) begin
      out_polar_angle_r   <= pol_nxt[vtsa_pkg::OUT_POL_W-1:0];
      out_azimuth_angle_r <= az_nxt[vtsa_pkg::OUT_AZ_W-1:0];
      out_zero_length_r   <= ln_zero_r[NL-1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_polar_angle   = out_polar_angle_r;
  assign out_azimuth_angle = out_azimuth_angle_r;
  assign out_zero_length   = out_zero_length_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_v_r[SQ] && sq_vec_r[SQ].zero) |-> (sq_root_r[SQ] == '0))
    else $error("zero vector produced nonzero horizontal length");

  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    ln_v_r[NS] |->
      ((ln_pol_r[NS].bzero || ln_pol_r[NS].ma[vtsa_pkg::MAW-1:vtsa_pkg::NORM_TOP] != '0) &&
       (ln_az_r[NS].bzero || ln_az_r[NS].ma[vtsa_pkg::MAW-1:vtsa_pkg::NORM_TOP] != '0)))
    else $error("normalization left magnitude below 2^30");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_length_r) |->
      (out_polar_angle_r == '0 && out_azimuth_angle_r == '0))
    else $error("zero-length result with nonzero angle");

  a_pol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({4'b0, out_polar_angle_r} <= vtsa_pkg::OUT_PI))
    else $error("polar angle above pi");

  a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_azimuth_angle_r <= vtsa_pkg::OUT_PI) &&
                     (out_azimuth_angle_r >= -vtsa_pkg::OUT_PI)))
    else $error("azimuth outside +/-pi");

endmodule

`default_nettype wire

// ===== test/vector_to_spherical_angles_tb.sv =====
// Self-checking testbench for the vector_to_spherical_angles pipeline.
// Depends on vtsa_pkg and the vector_to_spherical_angles RTL top level.
`timescale 1ns / 100ps

module vector_to_spherical_angles_tb;

  localparam int XW        = vtsa_pkg::XW;
  localparam int OUT_POL_W = vtsa_pkg::OUT_POL_W;
  localparam int OUT_AZ_W  = vtsa_pkg::OUT_AZ_W;

  localparam int STEPS        = 16;      // CORDIC iterations, passed to the block
  localparam int WATCHDOG_MAX = 4000;    // quiet cycles before giving up
  localparam int DRAIN_CYCLES = 41 + STEPS + 20;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [XW-1:0] COMP_MAX = 24'sh7FFFFF;
  localparam logic signed [XW-1:0] COMP_MIN = 24'sh800000;

  // pi in 2^-30 rad units, and pi in output units (2^-13 rad)
  localparam longint HALF_TURN = 64'sd3373259426;
  localparam longint PI_OUT    = 64'sd25736;

  // One result transaction as seen on the out_* ports
  typedef struct packed {
    logic [OUT_POL_W-1:0]       polar;
    logic signed [OUT_AZ_W-1:0] azimuth;
    logic                       zero;
  } angles_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [XW-1:0]  in_vec_x = '0;
  logic signed [XW-1:0]  in_vec_y = '0;
  logic signed [XW-1:0]  in_vec_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_POL_W-1:0]  out_polar_angle;
  logic signed [OUT_AZ_W-1:0] out_azimuth_angle;
  logic                  out_zero_length;

  // floor(atan(2^-i) * 2^30), one entry per CORDIC step
  longint atan_step [32] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047,
    1023, 511, 255, 127,
    63, 31, 15, 7,
    3, 1, 0, 0
  };

  angles_t expected_angles[$];   // predictions waiting for their result

  bit idle_on     = 1'b1;        // random gaps and stalls enabled
  int stall_cnt   = 0;
  int quiet_cycles = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_zero      = 0;
  int n_errors    = 0;

  vector_to_spherical_angles #(
    .CORDIC_STEPS(STEPS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_vec_x         (in_vec_x),
    .in_vec_y         (in_vec_y),
    .in_vec_z         (in_vec_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_polar_angle  (out_polar_angle),
    .out_azimuth_angle(out_azimuth_angle),
    .out_zero_length  (out_zero_length)
  );

  always #2 clk = ~clk;

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // floor(sqrt(v)), bit-by-bit
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    longint unsigned rem;
    res   = 0;
    rem   = v;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // atan2(b, a) in 2^-13 rad, rounded half up, not yet clamped
  function automatic longint atan2_fixed(input longint b_in, input longint a_in);
    longint a;
    longint b;
    longint t;
    longint acc;
    longint mag;
    int     i;
    int     s;
    a   = a_in;
    b   = b_in;
    acc = 0;
    // on the horizontal axis the answer is exact
    if (b == 0) return (a >= 0) ? 64'sd0 : PI_OUT;
    // left half plane: rotate by pi first
    if (a < 0) begin
      acc = (b > 0) ? HALF_TURN : -HALF_TURN;
      a   = -a;
      b   = -b;
    end
    mag = (b < 0) ? -b : b;
    if (a > mag) mag = a;
    while (mag < (64'sd1 << 30)) begin
      mag = mag * 2;
      a   = a * 2;
      b   = b * 2;
    end
    for (i = 0; i < STEPS; i++) begin
      s = i % 32;
      if (b > 0) begin
        t   = a + (b >>> s);
        b   = b - (a >>> s);
        acc = acc + atan_step[s];
      end else begin
        t   = a - (b >>> s);
        b   = b + (a >>> s);
        acc = acc - atan_step[s];
      end
      a = t;
    end
    return (acc + 64'sd65536) >>> 17;
  endfunction

  function automatic angles_t predict_angles(input logic signed [XW-1:0] x,
                                             input logic signed [XW-1:0] y,
                                             input logic signed [XW-1:0] z);
    angles_t         e;
    longint          xs;
    longint          ys;
    longint          zs;
    longint          pol;
    longint          az;
    longint unsigned rad;
    xs = x;
    ys = y;
    zs = z;
    if (xs == 0 && ys == 0 && zs == 0) begin
      e.polar   = '0;
      e.azimuth = '0;
      e.zero    = 1'b1;
      return e;
    end
    // horizontal length with 8 fraction bits; z scaled to match
    rad = xs * xs + ys * ys;
    rad = rad << 16;
    pol = atan2_fixed(longint'(root64(rad)), zs * 256);
    az  = atan2_fixed(ys, xs);
    if (pol < 0) pol = 0;
    if (pol > PI_OUT) pol = PI_OUT;
    if (az < -PI_OUT) az = -PI_OUT;
    if (az > PI_OUT) az = PI_OUT;
    e.polar   = pol[OUT_POL_W-1:0];
    e.azimuth = az[OUT_AZ_W-1:0];
    e.zero    = 1'b0;
    return e;
  endfunction

  // ------------------------------------------------------------------
  // Monitor and checker: both channels sampled at the rising edge.
  // The input side is handled first so a prediction is always queued
  // before its result could be compared.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    angles_t want;
    angles_t got;
    bit      in_take;
    bit      out_take;
    in_take  = rst_n && in_valid && !in_stall;
    out_take = rst_n && out_valid && !out_stall;
    if (in_take) begin
      expected_angles.push_back(predict_angles(in_vec_x, in_vec_y, in_vec_z));
      n_sent++;
    end
    if (out_take) begin
      got.polar   = out_polar_angle;
      got.azimuth = out_azimuth_angle;
      got.zero    = out_zero_length;
      if (expected_angles.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] unexpected result: polar=%0d azimuth=%0d zero=%0b",
                   $realtime, got.polar, got.azimuth, got.zero);
      end else begin
        want = expected_angles.pop_front();
        n_checked++;
        if (got.zero) n_zero++;
        if (got.polar !== want.polar || got.azimuth !== want.azimuth ||
            got.zero !== want.zero) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("[%0t] result %0d mismatch: polar %0d/%0d azimuth %0d/%0d zero %0b/%0b",
                     $realtime, n_checked, want.polar, got.polar,
                     want.azimuth, got.azimuth, want.zero, got.zero);
        end
      end
    end
    // watchdog: count cycles in which no transaction moves on either side
    if (rst_n) quiet_cycles = (in_take || out_take) ? 0 : quiet_cycles + 1;
  end

  initial begin
    wait (rst_n);
    while (quiet_cycles < WATCHDOG_MAX) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_MAX, expected_angles.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // Result side back-pressure: random stall bursts separated by
  // free-running stretches; nothing new once idling is switched off.
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_cnt <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
      stall_cnt <= idle_on ? $urandom_range(0, 12) : 0;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Drive one vector at the falling edge (after an optional gap) and
  // hold it until the block takes the transaction.
  task automatic send_vector(input logic signed [XW-1:0] x,
                             input logic signed [XW-1:0] y,
                             input logic signed [XW-1:0] z);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_vec_x <= x;
    in_vec_y <= y;
    in_vec_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [XW-1:0] short_component();
    int m;
    m = $urandom_range(1, 300);
    return XW'(int'($urandom_range(0, 2 * m)) - m);
  endfunction

  // mostly axis-like and boundary values, to hit the exact-angle paths
  function automatic logic signed [XW-1:0] axis_component();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2:       return 24'sd1;
      3:       return -24'sd1;
      4:       return COMP_MAX;
      5:       return COMP_MIN;
      6:       return short_component();
      default: return XW'($urandom);
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // zero vector, the six axis directions, the component extremes and
  // vectors just off the negative x axis on both sides
  task automatic test_corner_vectors();
    send_vector('0, '0, '0);
    send_vector(24'sd1, '0, '0);
    send_vector(-24'sd1, '0, '0);
    send_vector('0, 24'sd1, '0);
    send_vector('0, -24'sd1, '0);
    send_vector('0, '0, 24'sd1);
    send_vector('0, '0, -24'sd1);
    send_vector(COMP_MAX, COMP_MAX, COMP_MAX);
    send_vector(COMP_MIN, COMP_MIN, COMP_MIN);
    send_vector(COMP_MIN, '0, '0);
    send_vector('0, COMP_MIN, '0);
    send_vector('0, '0, COMP_MIN);
    send_vector('0, '0, COMP_MAX);
    send_vector(COMP_MIN, 24'sd1, '0);
    send_vector(COMP_MIN, -24'sd1, '0);
    send_vector(COMP_MAX, COMP_MIN, COMP_MAX);
    send_vector(COMP_MIN, COMP_MAX, COMP_MIN);
    send_vector(-24'sd5, 24'sd3, -24'sd7);
    send_vector(24'sd1, 24'sd1, 24'sd1);
    send_vector(-24'sd1, -24'sd1, 24'sd1);
    send_vector(COMP_MAX, '0, COMP_MIN);
    send_vector(24'sd3, -24'sd4, '0);
    send_vector(COMP_MAX, 24'sd1, COMP_MIN);
  endtask

  // full-range random components
  task automatic test_random_vectors(input int count);
    repeat (count) send_vector(XW'($urandom), XW'($urandom), XW'($urandom));
  endtask

  // short vectors need many normalization shifts before the CORDIC
  task automatic test_short_vectors(input int count);
    repeat (count) send_vector(short_component(), short_component(), short_component());
  endtask

  // components drawn from axis and boundary values
  task automatic test_axis_mix(input int count);
    repeat (count) send_vector(axis_component(), axis_component(), axis_component());
  endtask

  // full rate: no gaps, no stalls, random mix of all kinds
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) begin
      case ($urandom_range(0, 2))
        0:       send_vector(XW'($urandom), XW'($urandom), XW'($urandom));
        1:       send_vector(short_component(), short_component(), short_component());
        default: send_vector(axis_component(), axis_component(), axis_component());
      endcase
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_corner_vectors();
    test_random_vectors(700);
    test_short_vectors(500);
    test_axis_mix(420);
    test_back_to_back(310);

    @(negedge clk);
    in_valid <= 1'b0;

    // wait for the pipe to empty, then watch for stray results
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d vectors (corner, full-range, short, axis-mix, full-rate);",
             n_sent);
    $display("%0d results compared, %0d zero-length, %0d errors",
             n_checked, n_zero, n_errors);
    if (n_errors == 0 && expected_angles.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/vtsa_pkg.sv
hw/rtl/vector_to_spherical_angles.sv
test/vector_to_spherical_angles_tb.sv
